>>> rtl/rtor_pkg.sv
// Shared types, constants and helpers for the route table with oldest-entry replacement.
package rtor_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SLOT_W = 7;
  localparam int KEY_W = 64;
  localparam int MAC_W = 48;
  localparam int TIME_W = 32;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic ACT_REMEMBER = 1'b0;
  localparam logic ACT_FIND     = 1'b1;

  typedef struct packed {
    logic              action;
    logic [KEY_W-1:0]  key_high;
    logic [KEY_W-1:0]  key_low;
    logic [MAC_W-1:0]  mac_address;
    logic [TIME_W-1:0] time_now;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [MAC_W-1:0]  mac_out;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
  } rsp_t;

  // one table row as held in the RAM
  typedef struct packed {
    logic [KEY_W-1:0]  key_high;
    logic [KEY_W-1:0]  key_low;
    logic [TIME_W-1:0] seen;
    logic [MAC_W-1:0]  mac;
  } entry_t;

  // read-return tag from the sequencer to the search datapath
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } scan_ctl_t;

  // slot index reported on the result: low SLOT_W bits, zero-extended if narrower
  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [SLOT_W+IDX_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, idx};
    return wide[SLOT_W-1:0];
  endfunction

endpackage

>>> rtl/rtor_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rtor_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/rtor_search.sv
// Search datapath: key compare on each returned row and running oldest-entry tracker.
module rtor_search (
  input  logic                     clk,
  input  rtor_pkg::scan_ctl_t      ctl,
  input  rtor_pkg::req_t           item,
  input  rtor_pkg::entry_t         rd,
  output logic                     match,
  output logic [rtor_pkg::IDX_W-1:0] oldest_idx
);
  import rtor_pkg::*;

  logic              key_eq;
  logic              row_empty;
  logic [TIME_W-1:0] oldest_seen;

  assign key_eq    = (rd.key_high == item.key_high) && (rd.key_low == item.key_low);
  assign row_empty = (rd.key_high == '0) && (rd.key_low == '0);
  // remember stops on a free row too; find only on the key itself
  assign match = ctl.vld && (key_eq || ((item.action == ACT_REMEMBER) && row_empty));

  // row 0 seeds the tracker; strict less-than keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (ctl.vld && !match && ((ctl.idx == '0) || (rd.seen < oldest_seen))) begin
      oldest_idx  <= ctl.idx;
      oldest_seen <= rd.seen;
    end
  end

endmodule

>>> rtl/route_table_oldest_replace_unit.sv
// Route table top level: sequencer around one table RAM and the search datapath.
// An empty key skips the scan; find and remember scan up to the row where the scan stops, and
//   remember then passes through a write state; the longest case is a remember that evicts.
// Throughput: one transaction at a time, set by the one-row-per-cycle scan; next request is
//   taken the cycle after the result is loaded.
// Reset: a clearing pass writes every RAM row to zero, with req_stall high.
module route_table_oldest_replace_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  rtor_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output rtor_pkg::rsp_t rsp
);
  import rtor_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_RESP
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] clr_idx;     // clearing pass row
  req_t             item;        // transaction being worked on
  logic [IDX_W-1:0] issue_idx;   // next row to read
  logic             issue_done;  // all rows have been read
  logic             rd_vld;      // RAM output holds row rd_idx this cycle
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] target_idx;  // row to write on a remember hit/free row
  logic             use_oldest;  // remember found nothing: replace oldest
  rsp_t             res;         // result staged for the output register

  // RAM interface
  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  entry_t           ram_wr_data;
  logic             ram_rd_en;
  entry_t           ram_rd_data;

  // search datapath interface
  scan_ctl_t        ctl;
  logic             match;
  logic [IDX_W-1:0] oldest_idx;

  logic             key_empty;
  logic             scan_stop;   // returned row ends the scan
  logic             rsp_load;    // staged result moves to the output register

  assign key_empty = (req.key_high == '0) && (req.key_low == '0);
  assign req_stall = (state != S_IDLE);

  // one read per cycle while scanning; a read issued past the stop point is dropped
  assign ram_rd_en = (state == S_SCAN) && !issue_done;

  // writes: zero rows during the clearing pass, then the remember update
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = target_idx;
    ram_wr_data = '0;
    if (state == S_CLEAR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_idx;
    end else if (state == S_WRITE) begin
      ram_wr_en            = 1'b1;
      ram_wr_addr          = use_oldest ? oldest_idx : target_idx;
      ram_wr_data.key_high = item.key_high;
      ram_wr_data.key_low  = item.key_low;
      ram_wr_data.seen     = item.time_now;
      ram_wr_data.mac      = item.mac_address;
    end
  end

  assign ctl.vld = rd_vld && (state == S_SCAN);
  assign ctl.idx = rd_idx;

  assign scan_stop = ctl.vld && (match || (rd_idx == LAST_IDX));
  // hand off once the output register is free or draining
  assign rsp_load  = (state == S_RESP) && (!rsp_valid || !rsp_stall);

  rtor_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(issue_idx),
    .rd_data(ram_rd_data)
  );

  rtor_search u_search (
    .clk       (clk),
    .ctl       (ctl),
    .item      (item),
    .rd        (ram_rd_data),
    .match     (match),
    .oldest_idx(oldest_idx)
  );

  // Sequencer. Only one transaction is in the table at a time and its write
  // lands before the next scan starts, so no read/write overlap on a row.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      rsp_valid  <= 1'b0;
      rd_vld     <= 1'b0;
      issue_done <= 1'b0;
      use_oldest <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            item       <= req;
            issue_idx  <= '0;
            issue_done <= 1'b0;
            rd_vld     <= 1'b0;
            use_oldest <= 1'b0;
            if (key_empty) begin
              // empty key: nothing stored, nothing found
              res   <= '0;
              state <= S_RESP;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!issue_done) begin
            issue_idx  <= issue_idx + 1'b1;
            issue_done <= (issue_idx == LAST_IDX);
          end
          rd_vld <= !issue_done && !scan_stop;
          rd_idx <= issue_idx;
          if (ctl.vld && match) begin
            target_idx  <= rd_idx;
            res.hit     <= 1'b1;
            res.slot    <= to_slot(rd_idx);
            res.evicted <= 1'b0;
            if (item.action == ACT_FIND) begin
              res.mac_out <= ram_rd_data.mac;
              state       <= S_RESP;
            end else begin
              res.mac_out <= '0;
              state       <= S_WRITE;
            end
          end else if (ctl.vld && (rd_idx == LAST_IDX)) begin
            if (item.action == ACT_FIND) begin
              res   <= '0;
              state <= S_RESP;
            end else begin
              // no match and no free row; tracker settles on this edge
              use_oldest <= 1'b1;
              state      <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          if (use_oldest) begin
            res.hit     <= 1'b1;
            res.mac_out <= '0;
            res.slot    <= to_slot(oldest_idx);
            res.evicted <= 1'b1;
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (rsp_load) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
